// File: hdl/lpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants shared by the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  localparam logic [5:0] MAX_LENGTH_RST    = 6'd60;
  localparam logic [7:0] CHECKSUM_SEED_RST = 8'h0E;

  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_CHECKSUM_SEED = 1'b1;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  localparam logic [1:0] ST_GOOD         = 2'd0;
  localparam logic [1:0] ST_BAD_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_TOO_LONG     = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK,
    PH_DRAIN
  } phase_e;

endpackage

// File: hdl/length_prefixed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Parses command, length, payload and XOR checksum bytes; emits good payloads, empty-frame results and error results.
// ----------------------------------------------------------------------------
// Payload bytes are written into an on-chip payload memory with a registered
// read port; when the checksum byte of a good frame with a payload arrives,
// the frame is read back from that memory at one payload byte per cycle
// (while the output is not stalled), so a good frame holds off the input
// while its payload is read back. Rejected frames, checksum errors and empty
// good frames give a single result in the cycle after their byte is taken.
// An abort transfer returns the parser to idle with no result.
module length_prefixed_frame_receiver #(
  parameter int unsigned PAYLOAD_DEPTH = lpfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // received bytes
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  // results
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] command_o,
  output logic [7:0] length_o,
  output logic       has_data_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] byte_index_o,
  output logic       last_o
);

  localparam int unsigned AddrW = $clog2(PAYLOAD_DEPTH);

  lpfr_pkg::phase_e phase_q, phase_d;

  logic [5:0] max_len_q;
  logic [7:0] seed_q;
  logic [7:0] frame_cmd_q, frame_cmd_d;
  logic [5:0] frame_len_q, frame_len_d;
  logic [5:0] fill_idx_q, fill_idx_d;
  logic [7:0] csum_q, csum_d;
  logic [5:0] rd_idx_q, rd_idx_d;

  logic [7:0] mem_q [PAYLOAD_DEPTH];
  logic [7:0] rdata_q;
  logic       mem_we;

  logic       out_valid_q, out_valid_d;
  logic       out_load;
  logic [1:0] status_q, status_d;
  logic [7:0] command_q, command_d;
  logic [7:0] length_q, length_d;
  logic       has_data_q, has_data_d;
  logic [7:0] data_byte_q, data_byte_d;
  logic [5:0] byte_index_q, byte_index_d;
  logic       last_q, last_d;

  logic       out_free;
  logic       in_acc;
  logic       is_byte;
  logic       too_long;
  logic [5:0] fill_next;
  logic [5:0] rd_next;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_byte   = in_acc && (op_i == lpfr_pkg::OP_BYTE);
  assign too_long  = (rx_byte_i > {2'b00, max_len_q}) ||
                     ({1'b0, rx_byte_i} > 9'(PAYLOAD_DEPTH));
  assign fill_next = fill_idx_q + 6'd1;
  assign rd_next   = rd_idx_q + 6'd1;

  // next state
  always_comb begin
    phase_d     = phase_q;
    frame_cmd_d = frame_cmd_q;
    frame_len_d = frame_len_q;
    fill_idx_d  = fill_idx_q;
    csum_d      = csum_q;
    rd_idx_d    = '0;
    if (in_acc && (op_i == lpfr_pkg::OP_ABORT)) begin
      phase_d = lpfr_pkg::PH_IDLE;
    end else begin
      case (phase_q)
        lpfr_pkg::PH_IDLE: begin
          if (is_byte) begin
            frame_cmd_d = rx_byte_i;
            fill_idx_d  = '0;
            csum_d      = seed_q ^ rx_byte_i;
            phase_d     = lpfr_pkg::PH_LENGTH;
          end
        end
        lpfr_pkg::PH_LENGTH: begin
          if (is_byte) begin
            if (too_long) begin
              phase_d = lpfr_pkg::PH_IDLE;
            end else begin
              frame_len_d = rx_byte_i[5:0];
              csum_d      = csum_q ^ rx_byte_i;
              fill_idx_d  = '0;
              phase_d     = (rx_byte_i[5:0] != 6'd0) ? lpfr_pkg::PH_PAYLOAD
                                                     : lpfr_pkg::PH_CHECK;
            end
          end
        end
        lpfr_pkg::PH_PAYLOAD: begin
          if (is_byte) begin
            csum_d     = csum_q ^ rx_byte_i;
            fill_idx_d = fill_next;
            if ((fill_next >= frame_len_q) || (fill_next == 6'd0)) begin
              phase_d = lpfr_pkg::PH_CHECK;
            end
          end
        end
        lpfr_pkg::PH_CHECK: begin
          if (is_byte) begin
            if ((rx_byte_i == csum_q) && (frame_len_q != 6'd0)) begin
              phase_d = lpfr_pkg::PH_DRAIN;
            end else begin
              phase_d = lpfr_pkg::PH_IDLE;
            end
          end
        end
        lpfr_pkg::PH_DRAIN: begin
          rd_idx_d = rd_idx_q;
          if (out_free) begin
            rd_idx_d = rd_next;
            if (rd_next == frame_len_q) begin
              phase_d = lpfr_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_d = lpfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    in_stall_o   = (phase_q == lpfr_pkg::PH_DRAIN) || (out_valid_q && out_stall_i);
    mem_we       = is_byte && (phase_q == lpfr_pkg::PH_PAYLOAD);
    out_load     = 1'b0;
    status_d     = lpfr_pkg::ST_GOOD;
    command_d    = frame_cmd_q;
    length_d     = {2'b00, frame_len_q};
    has_data_d   = 1'b0;
    data_byte_d  = '0;
    byte_index_d = '0;
    last_d       = 1'b1;
    case (phase_q)
      lpfr_pkg::PH_LENGTH: begin
        if (is_byte && too_long) begin
          out_load = 1'b1;
          status_d = lpfr_pkg::ST_TOO_LONG;
          length_d = rx_byte_i;
        end
      end
      lpfr_pkg::PH_CHECK: begin
        if (is_byte) begin
          if (rx_byte_i != csum_q) begin
            out_load = 1'b1;
            status_d = lpfr_pkg::ST_BAD_CHECKSUM;
          end else if (frame_len_q == 6'd0) begin
            out_load = 1'b1;
          end
        end
      end
      lpfr_pkg::PH_DRAIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          has_data_d   = 1'b1;
          data_byte_d  = rdata_q;
          byte_index_d = rd_idx_q;
          last_d       = (rd_next == frame_len_q);
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lpfr_pkg::PH_IDLE;
      max_len_q   <= lpfr_pkg::MAX_LENGTH_RST;
      seed_q      <= lpfr_pkg::CHECKSUM_SEED_RST;
      frame_cmd_q <= '0;
      frame_len_q <= '0;
      fill_idx_q  <= '0;
      csum_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_cmd_q <= frame_cmd_d;
      frame_len_q <= frame_len_d;
      fill_idx_q  <= fill_idx_d;
      csum_q      <= csum_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lpfr_pkg::CFG_MAX_LENGTH:    max_len_q <= cfg_wdata_i[5:0];
          lpfr_pkg::CFG_CHECKSUM_SEED: seed_q    <= cfg_wdata_i;
          default:                     seed_q    <= seed_q;
        endcase
      end
    end
  end

  // payload memory, read address follows the next drain index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AddrW'(fill_idx_q)] <= rx_byte_i;
    end
    rdata_q <= mem_q[AddrW'(rd_idx_d)];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q     <= status_d;
      command_q    <= command_d;
      length_q     <= length_d;
      has_data_q   <= has_data_d;
      data_byte_q  <= data_byte_d;
      byte_index_q <= byte_index_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign command_o    = command_q;
  assign length_o     = length_q;
  assign has_data_o   = has_data_q;
  assign data_byte_o  = data_byte_q;
  assign byte_index_o = byte_index_q;
  assign last_o       = last_q;

endmodule

// File: sim/length_prefixed_frame_receiver_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_check
// Watches the configuration port and both channels of the frame receiver,
// keeps its own copy of the frame parser and compares every result transfer,
// field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_check
  import lpfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] status_i,
  input  logic [7:0] command_i,
  input  logic [7:0] length_i,
  input  logic       has_data_i,
  input  logic [7:0] data_byte_i,
  input  logic [5:0] byte_index_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] len;
    logic       has_data;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last_flag;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [5:0] max_len;
  logic [7:0] seed;
  phase_e     parse_phase;
  logic [7:0] frame_cmd;
  logic [5:0] frame_len;
  logic [5:0] fill_idx;
  logic [7:0] run_sum;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];

  int mismatch_count = 0;
  int pending_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic push_result(input logic [1:0] st, input logic [7:0] len, input logic has,
                             input logic [7:0] d, input logic [5:0] idx, input logic lst);
    frame_result_t r;
    r.status     = st;
    r.command    = frame_cmd;
    r.len        = len;
    r.has_data   = has;
    r.data_byte  = d;
    r.byte_index = idx;
    r.last_flag  = lst;
    expected_results.push_back(r);
  endtask

  task automatic parse_rx_byte(input logic op, input logic [7:0] b);
    logic [7:0] d;
    if (op == OP_ABORT) begin
      parse_phase = PH_IDLE;
      return;
    end
    case (parse_phase)
      PH_IDLE: begin
        frame_cmd   = b;
        fill_idx    = '0;
        run_sum     = seed ^ b;
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (int'(b) > int'(max_len) || int'(b) > int'(PAYLOAD_DEPTH)) begin
          push_result(ST_TOO_LONG, b, 1'b0, 8'h00, 6'd0, 1'b1);
          parse_phase = PH_IDLE;
        end else begin
          frame_len   = b[5:0];
          run_sum     = run_sum ^ b;
          fill_idx    = '0;
          parse_phase = (frame_len > 0) ? PH_PAYLOAD : PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        if (int'(fill_idx) < int'(PAYLOAD_DEPTH)) payload_mem[fill_idx] = b;
        run_sum  = run_sum ^ b;
        fill_idx = fill_idx + 6'd1;
        if (fill_idx >= frame_len || fill_idx == 0) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b != run_sum) begin
          push_result(ST_BAD_CHECKSUM, {2'b00, frame_len}, 1'b0, 8'h00, 6'd0, 1'b1);
        end else if (frame_len == 0) begin
          push_result(ST_GOOD, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1);
        end else begin
          for (int i = 0; i < int'(frame_len); i++) begin
            d = (i < int'(PAYLOAD_DEPTH)) ? payload_mem[i] : 8'h00;
            push_result(ST_GOOD, {2'b00, frame_len}, 1'b1, d, i[5:0],
                        (i + 1 == int'(frame_len)));
          end
        end
        parse_phase = PH_IDLE;
      end
      default: begin
        parse_phase = PH_IDLE;
      end
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result transfer, status %0d command %02h",
                                status_i, command_i));
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", status_i, want.status);
    compare_field("command", command_i, want.command);
    compare_field("length", length_i, want.len);
    compare_field("has_data", has_data_i, want.has_data);
    compare_field("data_byte", data_byte_i, want.data_byte);
    compare_field("byte_index", byte_index_i, want.byte_index);
    compare_field("last", last_i, want.last_flag);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      max_len     = MAX_LENGTH_RST;
      seed        = CHECKSUM_SEED_RST;
      parse_phase = PH_IDLE;
      frame_cmd   = '0;
      frame_len   = '0;
      fill_idx    = '0;
      run_sum     = '0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_LENGTH) max_len = cfg_wdata_i[5:0];
        else seed = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) parse_rx_byte(op_i, rx_byte_i);
    end
    pending_count = expected_results.size();
  end

endmodule

// File: sim/length_prefixed_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_test
// Drives frames into the receiver: directed corner frames, then mostly
// well-formed random frames with bad checksums, oversize lengths, aborts and
// noise mixed in, over several register settings and with random stalls on
// both sides. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_test;
  import lpfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 16;
  localparam int IDLE_PCT     = 29;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic       op;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] command;
  logic [7:0] length;
  logic       has_data;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;

  int fail_count;
  int pending;

  bit         idle_en;
  int         hold_requests = 0;
  int         holds_served  = 0;
  int         hold_left     = 0;
  int         cycle_count   = 0;
  int         items_sent;
  logic [5:0] cur_max;
  logic [7:0] cur_seed;

  always #5 clk = ~clk;

  length_prefixed_frame_receiver dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .command_o    (command),
    .length_o     (length),
    .has_data_o   (has_data),
    .data_byte_o  (data_byte),
    .byte_index_o (byte_index),
    .last_o       (last)
  );

  length_prefixed_frame_receiver_check frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .command_i    (command),
    .length_i     (length),
    .has_data_i   (has_data),
    .data_byte_i  (data_byte),
    .byte_index_i (byte_index),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left == 0 && hold_requests > holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic push_byte(input logic op_v, input logic [7:0] b);
    if (idle_en) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    op       <= op_v;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_MAX_LENGTH) cur_max = d[5:0];
    else cur_seed = d;
  endtask

  task automatic settle();
    push_byte(OP_ABORT, 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_cs,
                            input int abort_at, input bit extreme);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] d;
    sum = cur_seed ^ cmd ^ len;
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len);
    if (len <= cur_max) begin
      for (int k = 0; k < int'(len); k++) begin
        d = extreme ? {8{k[0]}} : 8'($urandom_range(0, 255));
        sum ^= d;
        frame_bytes.push_back(d);
      end
      frame_bytes.push_back(bad_cs ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
    foreach (frame_bytes[k]) begin
      if (k == abort_at) begin
        push_byte(OP_ABORT, 8'($urandom_range(0, 255)));
        return;
      end
      push_byte(OP_BYTE, frame_bytes[k]);
    end
  endtask

  task automatic random_frame();
    int lim;
    int len;
    int pick;
    int abort_at;
    if ($urandom_range(0, 99) < 8) begin
      push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    lim  = (cur_max < 8) ? int'(cur_max) : 8;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, lim);
    else if (pick < 85) len = $urandom_range(0, cur_max);
    else if (pick < 93) len = cur_max;
    else len = $urandom_range(int'(cur_max) + 1, 255);
    abort_at = -1;
    if ($urandom_range(0, 99) < 8) abort_at = $urandom_range(0, len + 2);
    send_frame(8'($urandom_range(0, 255)), 8'(len), $urandom_range(0, 99) < 15, abort_at, 1'b0);
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_frame();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_MAX_LENGTH;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    op         = OP_BYTE;
    rx_byte    = '0;
    idle_en    = 1'b1;
    items_sent = 0;
    cur_max    = MAX_LENGTH_RST;
    cur_seed   = CHECKSUM_SEED_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty good frame, extreme payload, bad checksum, oversize lengths
    send_frame(8'h00, 8'd0, 1'b0, -1, 1'b0);
    send_frame(8'hFF, 8'd2, 1'b0, -1, 1'b1);
    send_frame(8'hA5, 8'd1, 1'b1, -1, 1'b0);
    send_frame(8'h3C, 8'd61, 1'b0, -1, 1'b0);
    send_frame(8'h5A, 8'hFF, 1'b0, -1, 1'b0);
    // abort in the idle, length, payload and checksum phases of the parser
    push_byte(OP_ABORT, 8'hFF);
    send_frame(8'h11, 8'd3, 1'b0, 1, 1'b0);
    send_frame(8'h22, 8'd3, 1'b0, 3, 1'b0);
    send_frame(8'h33, 8'd0, 1'b0, 2, 1'b0);
    settle();

    // longest frame and an oversize one with no idling on either side
    write_reg(CFG_MAX_LENGTH, 8'hFF);
    write_reg(CFG_CHECKSUM_SEED, 8'hFF);
    idle_en = 1'b0;
    send_frame(8'hC3, 8'd63, 1'b0, -1, 1'b1);
    send_frame(8'h3C, 8'd64, 1'b0, -1, 1'b0);
    run_random(8);
    idle_en = 1'b1;
    settle();

    write_reg(CFG_MAX_LENGTH, 8'hC0);
    write_reg(CFG_CHECKSUM_SEED, 8'h00);
    run_random(4);
    settle();

    // result side holds off while good frames keep coming
    write_reg(CFG_MAX_LENGTH, 8'($urandom_range(16, 63)));
    write_reg(CFG_CHECKSUM_SEED, 8'($urandom_range(0, 255)));
    hold_requests++;
    repeat (2) send_frame(8'($urandom_range(0, 255)), 8'd4, 1'b0, -1, 1'b0);
    settle();

    write_reg(CFG_MAX_LENGTH, {2'b00, MAX_LENGTH_RST});
    write_reg(CFG_CHECKSUM_SEED, CHECKSUM_SEED_RST);
    run_random(6);
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lpfr_pkg.sv
hdl/length_prefixed_frame_receiver.sv
sim/length_prefixed_frame_receiver_check.sv
sim/length_prefixed_frame_receiver_test.sv
